// File: sv/trimmed_mean_adc_filter_assert.svh
// assertion macros used by the checker file
`ifndef TRIMMED_MEAN_ADC_FILTER_ASSERT_SVH
`define TRIMMED_MEAN_ADC_FILTER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TMAF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TMAF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tmaf_pkg.sv
// package with constants shared by the trimmed-mean filter modules
package tmaf_pkg;

  localparam int SAMPLE_W         = 10;
  localparam int MV_W             = 16;
  localparam int BLOCK_SIZE_DEF   = 19;
  localparam int DISCARD_DEF      = 4;
  localparam int MV_NUM           = 100;
  localparam int MV_DEN           = 31;
  localparam int MV_NUM_W         = 7;
  localparam logic [MV_W-1:0] MV_MAX = '1;

endpackage

// File: sv/trimmed_mean_adc_filter.sv
// trimmed-mean ADC filter top level: block collection and rank sequencer
//
// Samples are taken one per cycle while busy is low. The beat that
// completes a block of BLOCK_SIZE samples raises busy for the trim pass:
// every stored sample is ranked against all others by streaming the store
// through its single read port, followed by the millivolt scaling unit
// (a multiply by 100, then a reciprocal multiply that divides by 31).
// The result appears on voltage_mv_o as busy drops, with done_o high for
// exactly one cycle; it cannot be held off, so capture it then.
module trimmed_mean_adc_filter import tmaf_pkg::*; #(
  parameter int BLOCK_SIZE       = BLOCK_SIZE_DEF,
  parameter int DISCARD_EACH_END = DISCARD_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                done_o,
  output logic [MV_W-1:0]     voltage_mv_o
);

  localparam int IDX_W = $clog2(BLOCK_SIZE);
  localparam int CNT_W = $clog2(BLOCK_SIZE + 1);
  localparam int SUM_W = $clog2(BLOCK_SIZE * ((1 << SAMPLE_W) - 1) + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(BLOCK_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OUTER,
    S_KEY,
    S_INNER,
    S_SCALE
  } state_e;

  state_e              state_q;
  logic [IDX_W-1:0]    fill_q;
  logic [IDX_W-1:0]    i_q;
  logic [CNT_W-1:0]    rd_q;
  logic                cmp_v_q;
  logic [IDX_W-1:0]    cmp_idx_q;
  logic [IDX_W-1:0]    rank_q;
  logic [SAMPLE_W-1:0] key_q;
  logic [SUM_W-1:0]    sum_q;
  logic                valid_q;
  logic [MV_W-1:0]     mv_q;

  logic                accept;
  logic [IDX_W-1:0]    raddr;
  logic [SAMPLE_W-1:0] rdata;
  logic                less;
  logic [IDX_W-1:0]    rank_nxt;
  logic                keep;
  logic                elem_done;
  logic [SUM_W-1:0]    sum_nxt;
  logic                scale_go;
  logic                scale_done;
  logic [MV_W-1:0]     scale_mv;

  assign accept = start && (state_q == S_IDLE);

  always_comb begin
    case (state_q)
      S_OUTER: raddr = i_q;
      S_KEY:   raddr = '0;
      S_INNER: raddr = rd_q[IDX_W-1:0];
      default: raddr = i_q;
    endcase
  end

  // ties are broken by store index so every sample gets a distinct rank
  always_comb begin
    less      = (rdata < key_q) || ((rdata == key_q) && (cmp_idx_q < i_q));
    rank_nxt  = rank_q + IDX_W'(less);
    keep      = (32'(rank_nxt) >= DISCARD_EACH_END) &&
                ((32'(rank_nxt) + DISCARD_EACH_END) < BLOCK_SIZE);
    elem_done = (state_q == S_INNER) && cmp_v_q && (cmp_idx_q == LAST);
    sum_nxt   = keep ? (sum_q + SUM_W'(key_q)) : sum_q;
    scale_go  = elem_done && (i_q == LAST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      i_q       <= '0;
      rd_q      <= '0;
      cmp_v_q   <= 1'b0;
      cmp_idx_q <= '0;
      rank_q    <= '0;
      sum_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (fill_q == LAST) begin
              fill_q  <= '0;
              i_q     <= '0;
              sum_q   <= '0;
              state_q <= S_OUTER;
            end else begin
              fill_q <= fill_q + IDX_W'(1);
            end
          end
        end
        S_OUTER: begin
          state_q <= S_KEY;
        end
        S_KEY: begin
          rd_q      <= CNT_W'(1);
          cmp_v_q   <= 1'b1;
          cmp_idx_q <= '0;
          rank_q    <= '0;
          state_q   <= S_INNER;
        end
        S_INNER: begin
          if (rd_q < CNT_W'(BLOCK_SIZE)) begin
            rd_q      <= rd_q + CNT_W'(1);
            cmp_v_q   <= 1'b1;
            cmp_idx_q <= rd_q[IDX_W-1:0];
          end else begin
            cmp_v_q <= 1'b0;
          end
          if (cmp_v_q) begin
            rank_q <= rank_nxt;
          end
          if (elem_done) begin
            sum_q <= sum_nxt;
            if (i_q == LAST) begin
              state_q <= S_SCALE;
            end else begin
              i_q     <= i_q + IDX_W'(1);
              state_q <= S_OUTER;
            end
          end
        end
        S_SCALE: begin
          if (scale_done) begin
            valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_KEY) begin
      key_q <= rdata;
    end
    if (scale_done) begin
      mv_q <= scale_mv;
    end
  end

  tmaf_store #(
    .DEPTH(BLOCK_SIZE)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(fill_q),
    .wdata_i(sample_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  tmaf_scale #(
    .SUM_W(SUM_W)
  ) u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(scale_go),
    .sum_i  (sum_nxt),
    .done_o (scale_done),
    .mv_o   (scale_mv)
  );

  assign busy         = (state_q != S_IDLE);
  assign done_o       = valid_q;
  assign voltage_mv_o = mv_q;

endmodule

// File: sv/tmaf_store.sv
// sample store: single-port-write, registered-read memory
module tmaf_store import tmaf_pkg::*; #(
  parameter int DEPTH = BLOCK_SIZE_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [SAMPLE_W-1:0]      wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [SAMPLE_W-1:0]      rdata_o
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tmaf_scale.sv
// millivolt scaling: sum * 100, then divide by 31 through a reciprocal multiply
module tmaf_scale import tmaf_pkg::*; #(
  parameter int SUM_W = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] sum_i,
  output logic             done_o,
  output logic [MV_W-1:0]  mv_o
);

  localparam int XW    = SUM_W + MV_NUM_W;
  // 31 < 2**5, so five extra fraction bits keep the rounded-up reciprocal exact
  localparam int SHIFT = XW + 5;
  localparam int RW    = SHIFT - 4;
  localparam int PW    = XW + RW;
  localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(MV_DEN - 1)) /
                             longint'(MV_DEN);
  localparam logic [RW-1:0] RECIP_C = RW'(RECIP);

  logic [XW-1:0] x_q;
  logic [XW-1:0] q_q;
  logic          stage_q;
  logic          done_q;
  logic [PW-1:0] prod;
  logic [XW-1:0] q_d;

  always_comb begin
    prod = PW'(x_q) * PW'(RECIP_C);
    q_d  = XW'(prod >> SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= start_i;
      done_q  <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= XW'(sum_i) * XW'(MV_NUM);
    end
    if (stage_q) begin
      q_q <= q_d;
    end
  end

  assign done_o = done_q;
  assign mv_o   = (|q_q[XW-1:MV_W]) ? MV_MAX : q_q[MV_W-1:0];

endmodule

// File: sv/tmaf_checker.sv
// port-level checker for the trimmed-mean filter, bound to the top level
`include "trimmed_mean_adc_filter_assert.svh"

module tmaf_checker import tmaf_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic [SAMPLE_W-1:0] sample_i,
  input logic                done_o,
  input logic [MV_W-1:0]     voltage_mv_o
);

  logic sample_seen;
  assign sample_seen = ^sample_i | ~^sample_i;

  `TMAF_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy, "result beat while busy")
  `TMAF_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result strobe longer than one cycle")
  `TMAF_ASSERT_IMP(a_busy_fall, clk_i, rst_ni, $fell(busy), done_o, "busy dropped without a result")
  `TMAF_ASSERT_IMP(a_busy_rise, clk_i, rst_ni, $rose(busy), $past(start) && sample_seen, "busy rose without an accepted beat")

endmodule

bind trimmed_mean_adc_filter tmaf_checker u_tmaf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .sample_i    (sample_i),
  .done_o      (done_o),
  .voltage_mv_o(voltage_mv_o)
);

// File: tb/trimmed_mean_adc_filter_test.sv
// testbench for the trimmed-mean ADC filter: random sample blocks checked against a predictor
`timescale 1ns / 100ps

module trimmed_mean_adc_filter_test;
  import tmaf_pkg::*;

  localparam int RANDOM_ITEMS = 29 * BLOCK_SIZE_DEF + 7;
  localparam int DRAIN_CYCLES = 500;

  typedef enum {
    MIX_UNIFORM,
    MIX_CLUSTER,
    MIX_EXTREMES,
    MIX_FLAT,
    MIX_OUTLIERS
  } block_mix_e;

  class voltage_scoreboard;
    logic [SAMPLE_W-1:0] block_buf [BLOCK_SIZE_DEF];
    int unsigned         fill;
    logic [MV_W-1:0]     pending_mv [$];
    int unsigned         errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // sort the block, drop both ends, scale the middle sum to millivolts
    function logic [MV_W-1:0] trimmed_mv();
      logic [SAMPLE_W-1:0] ranked [BLOCK_SIZE_DEF];
      logic [SAMPLE_W-1:0] key;
      int                  j;
      int unsigned         sum;
      int unsigned         mv;
      ranked = block_buf;
      for (int i = 1; i < BLOCK_SIZE_DEF; i++) begin
        key = ranked[i];
        j   = i;
        while (j > 0 && ranked[j-1] > key) begin
          ranked[j] = ranked[j-1];
          j--;
        end
        ranked[j] = key;
      end
      sum = 0;
      if (2 * DISCARD_DEF < BLOCK_SIZE_DEF) begin
        for (int i = DISCARD_DEF; i < BLOCK_SIZE_DEF - DISCARD_DEF; i++)
          sum += ranked[i];
      end
      mv = sum * MV_NUM / MV_DEN;
      if (mv > MV_MAX) mv = MV_MAX;
      return mv[MV_W-1:0];
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      block_buf[fill] = s;
      fill++;
      if (fill == BLOCK_SIZE_DEF) begin
        fill = 0;
        pending_mv.push_back(trimmed_mv());
      end
    endfunction

    function void check_voltage(logic [MV_W-1:0] got);
      logic [MV_W-1:0] want;
      if (pending_mv.size() == 0) begin
        $error("voltage_mv: expected none, actual %0d", got);
        errors++;
      end else begin
        want = pending_mv.pop_front();
        if (got !== want) begin
          $error("voltage_mv: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  // extremes, alternating bit patterns, duplicates around the trim boundary
  localparam logic [SAMPLE_W-1:0] DIRECTED [BLOCK_SIZE_DEF] = '{
    10'h000, 10'h3FF, 10'h000, 10'h3FF, 10'h155, 10'h2AA, 10'h001, 10'h3FE,
    10'h200, 10'h1FF, 10'h000, 10'h000, 10'h3FF, 10'h3FF, 10'h155, 10'h155,
    10'h2AA, 10'h0F0, 10'h30F
  };

  // receiver cannot stall; the first and third phases run with no sender gaps
  int unsigned sender_idle_pct [4] = '{0, 77, 0, 9};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [SAMPLE_W-1:0] sample_i;
  logic                done_o;
  logic [MV_W-1:0]     voltage_mv_o;

  voltage_scoreboard sb;

  trimmed_mean_adc_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .sample_i    (sample_i),
    .done_o      (done_o),
    .voltage_mv_o(voltage_mv_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample(block_mix_e mix, int unsigned level);
    case (mix)
      MIX_UNIFORM:  return SAMPLE_W'($urandom_range(1023, 0));
      MIX_CLUSTER:  return SAMPLE_W'(level + $urandom_range(31, 0));
      MIX_EXTREMES: return $urandom_range(1, 0) ? 10'h3FF : 10'h000;
      MIX_FLAT:     return SAMPLE_W'(level);
      default: begin
        // a few outliers around a tight cluster, mostly trimmed away
        if ($urandom_range(3, 0) == 0) return $urandom_range(1, 0) ? 10'h3FF : 10'h000;
        return SAMPLE_W'(level + $urandom_range(31, 0));
      end
    endcase
  endfunction

  task automatic drive_sample(input logic [SAMPLE_W-1:0] s, input int unsigned idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    sample_i <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_sample(s);
  endtask

  // a result beat lives for one cycle only
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_voltage(voltage_mv_o);
  end

  initial begin
    block_mix_e  mix;
    int unsigned level;
    int unsigned pick;
    sb = new();
    start    <= 1'b0;
    sample_i <= '0;
    rst_ni   <= 1'b0;
    mix   = MIX_UNIFORM;
    level = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) drive_sample(DIRECTED[i], 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (sb.fill == 0) begin
        mix = block_mix_e'($urandom_range(4, 0));
        case (mix)
          MIX_FLAT: begin
            pick = $urandom_range(2, 0);
            level = (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(1023, 0);
          end
          default: level = $urandom_range(1023 - 31, 0);
        endcase
      end
      drive_sample(pick_sample(mix, level), sender_idle_pct[n * 4 / RANDOM_ITEMS]);
    end
    start <= 1'b0;

    while (sb.pending_mv.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending_mv.size() != 0) begin
      $error("voltage_mv: %0d results never arrived", sb.pending_mv.size());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("trimmed_mean_adc_filter test passed");
    end else begin
      $display("trimmed_mean_adc_filter test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("trimmed_mean_adc_filter test failed");
    $finish;
  end

endmodule
